// ===== rtl/core/sctc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctc_pkg - shared types and constants of the subtitle cue timing checker
// Issue codes, severities, register map, reset values and the queue word.
// ----------------------------------------------------------------------------
package sctc_pkg;

  // Default widths and sizes
  localparam int TIME_WIDTH_DEFAULT  = 32;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Field widths fixed by the interface
  localparam int FIELD_TIME_WIDTH = 32;
  localparam int CUE_WIDTH        = 16;
  localparam int CHARS_WIDTH      = 16;
  localparam int CPS_WIDTH        = 16;
  localparam int ENABLE_WIDTH     = 5;
  localparam int CODE_WIDTH       = 3;
  localparam int SEV_WIDTH        = 2;
  localparam int NUM_ISSUES       = 8;

  // Configuration port
  localparam int CFG_DATA_WIDTH = 32;
  localparam int CFG_ADDR_WIDTH = 5;
  localparam int REG_IDX_WIDTH  = 3;

  localparam logic [REG_IDX_WIDTH-1:0] REG_CHECK_ENABLES = 3'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_MIN_DURATION  = 3'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_MAX_DURATION  = 3'd2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_OVERLAP_TOL   = 3'd3;
  localparam logic [REG_IDX_WIDTH-1:0] REG_MAX_CPS       = 3'd4;
  localparam logic [REG_IDX_WIDTH-1:0] REG_MEDIA_LENGTH  = 3'd5;

  // Reset values of the registers
  localparam logic [ENABLE_WIDTH-1:0]     RST_CHECK_ENABLES = 5'h1F;
  localparam logic [FIELD_TIME_WIDTH-1:0] RST_MIN_DURATION  = 32'h0000_0000;
  localparam logic [FIELD_TIME_WIDTH-1:0] RST_MAX_DURATION  = 32'hFFFF_FFFF;
  localparam logic [FIELD_TIME_WIDTH-1:0] RST_OVERLAP_TOL   = 32'h0000_0000;
  localparam logic [CPS_WIDTH-1:0]        RST_MAX_CPS       = 16'hFFFF;
  localparam logic [FIELD_TIME_WIDTH-1:0] RST_MEDIA_LENGTH  = 32'h0000_0000;

  // Bits of check_enables
  localparam int EN_EMPTY    = 0;
  localparam int EN_DURATION = 1;
  localparam int EN_ORDER    = 2;
  localparam int EN_OVERLAP  = 3;
  localparam int EN_SPEED    = 4;

  // Issue codes; each is also its bit in the issue mask
  localparam logic [CODE_WIDTH-1:0] ISSUE_EMPTY        = 3'd0;
  localparam logic [CODE_WIDTH-1:0] ISSUE_BAD_DURATION = 3'd1;
  localparam logic [CODE_WIDTH-1:0] ISSUE_SHORT        = 3'd2;
  localparam logic [CODE_WIDTH-1:0] ISSUE_LONG         = 3'd3;
  localparam logic [CODE_WIDTH-1:0] ISSUE_ORDER        = 3'd4;
  localparam logic [CODE_WIDTH-1:0] ISSUE_OVERLAP      = 3'd5;
  localparam logic [CODE_WIDTH-1:0] ISSUE_FAST         = 3'd6;
  localparam logic [CODE_WIDTH-1:0] ISSUE_RANGE        = 3'd7;

  localparam logic [SEV_WIDTH-1:0] SEV_INFO    = 2'd0;
  localparam logic [SEV_WIDTH-1:0] SEV_WARNING = 2'd1;
  localparam logic [SEV_WIDTH-1:0] SEV_ERROR   = 2'd2;

  // Timing constants
  localparam int RANGE_SLACK_MS     = 500;
  localparam int SPEED_MIN_DUR_MS   = 200;
  localparam int CPS_SCALE          = 10000;
  localparam int CPS_SCALE_WIDTH    = 14;
  localparam int CHARS_PROD_WIDTH   = CHARS_WIDTH + CPS_SCALE_WIDTH;

  typedef struct packed {
    logic [ENABLE_WIDTH-1:0]     check_enables;
    logic [FIELD_TIME_WIDTH-1:0] min_duration_ms;
    logic [FIELD_TIME_WIDTH-1:0] max_duration_ms;
    logic [FIELD_TIME_WIDTH-1:0] overlap_tolerance_ms;
    logic [CPS_WIDTH-1:0]        max_cps_tenths;
    logic [FIELD_TIME_WIDTH-1:0] media_length_ms;
  } sctc_cfg_t;

  // One queued cue: the set of findings and the cue it belongs to
  typedef struct packed {
    logic [NUM_ISSUES-1:0] mask;
    logic [CUE_WIDTH-1:0]  cue;
  } sctc_entry_t;

  function automatic logic [SEV_WIDTH-1:0] issue_severity(input logic [CODE_WIDTH-1:0] code);
    logic [SEV_WIDTH-1:0] sev;
    unique case (code)
      ISSUE_EMPTY:        sev = SEV_WARNING;
      ISSUE_BAD_DURATION: sev = SEV_ERROR;
      ISSUE_SHORT:        sev = SEV_WARNING;
      ISSUE_LONG:         sev = SEV_WARNING;
      ISSUE_ORDER:        sev = SEV_ERROR;
      ISSUE_OVERLAP:      sev = SEV_WARNING;
      ISSUE_FAST:         sev = SEV_INFO;
      ISSUE_RANGE:        sev = SEV_WARNING;
      default:            sev = SEV_INFO;
    endcase
    return sev;
  endfunction

endpackage

// ===== rtl/core/sctc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctc_front - cue intake and classification
// Two-stage pipeline: compare stage with previous-cue tracking, then the
// reading-speed cross products; pushes nonempty issue masks to the queue.
// ----------------------------------------------------------------------------
module sctc_front #(
  parameter int TIME_WIDTH = sctc_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  sctc_pkg::sctc_cfg_t                    cfg,
  input  logic                                   cue_valid,
  output logic                                   cue_stall,
  input  logic                                   group_start,
  input  logic [sctc_pkg::CUE_WIDTH-1:0]         cue_id,
  input  logic [sctc_pkg::FIELD_TIME_WIDTH-1:0]  start_ms,
  input  logic [sctc_pkg::FIELD_TIME_WIDTH-1:0]  end_ms,
  input  logic                                   is_empty,
  input  logic [sctc_pkg::CHARS_WIDTH-1:0]       text_chars,
  output logic                                   push,
  output sctc_pkg::sctc_entry_t                  push_entry,
  input  logic                                   queue_full
);

  localparam int TW = TIME_WIDTH;
  // wide enough for a time plus a 32-bit register without overflow
  localparam int WW = ((TW > sctc_pkg::FIELD_TIME_WIDTH) ? TW : sctc_pkg::FIELD_TIME_WIDTH) + 1;
  localparam int PW = sctc_pkg::CPS_WIDTH + TW;

  // previous-cue tracking
  logic [TW-1:0] last_start;
  logic [TW-1:0] last_end;
  logic          have_prev;

  // stage 1
  logic                                 s1_valid;
  logic [sctc_pkg::NUM_ISSUES-1:0]      s1_mask;
  logic [sctc_pkg::CUE_WIDTH-1:0]       s1_cue;
  logic                                 s1_speed;
  logic [TW-1:0]                        s1_dur;
  logic [sctc_pkg::CHARS_WIDTH-1:0]     s1_chars;

  // stage 2
  logic                                 s2_valid;
  logic [sctc_pkg::NUM_ISSUES-1:0]      s2_mask;
  logic [sctc_pkg::CUE_WIDTH-1:0]       s2_cue;
  logic                                 s2_speed;
  logic [sctc_pkg::CHARS_PROD_WIDTH-1:0] s2_chars_prod;
  logic [PW-1:0]                        s2_limit_prod;

  logic          accept;
  logic          adv1;
  logic          adv2;
  logic [TW-1:0] start_t;
  logic [TW-1:0] end_t;
  logic          positive;
  logic [TW-1:0] dur;
  logic          prev_ok;
  logic          dur_check;
  logic          f_short;
  logic          f_order;
  logic [sctc_pkg::NUM_ISSUES-1:0] mask_c;
  logic [sctc_pkg::NUM_ISSUES-1:0] s2_mask_full;
  logic          fast;

  assign start_t  = TW'(start_ms);
  assign end_t    = TW'(end_ms);
  assign positive = end_t > start_t;
  assign dur      = end_t - start_t;
  assign prev_ok  = have_prev && !group_start;

  assign dur_check = cfg.check_enables[sctc_pkg::EN_DURATION] && (end_t != '0);
  assign f_short   = positive && (WW'(dur) < WW'(cfg.min_duration_ms));
  assign f_order   = prev_ok && cfg.check_enables[sctc_pkg::EN_ORDER] && (start_t < last_start);

  always_comb begin
    mask_c = '0;
    mask_c[sctc_pkg::ISSUE_EMPTY] = cfg.check_enables[sctc_pkg::EN_EMPTY] && is_empty;
    mask_c[sctc_pkg::ISSUE_BAD_DURATION] = dur_check && !positive;
    mask_c[sctc_pkg::ISSUE_SHORT] = dur_check && f_short;
    mask_c[sctc_pkg::ISSUE_LONG] = dur_check && positive && !f_short &&
                                   (WW'(dur) > WW'(cfg.max_duration_ms));
    mask_c[sctc_pkg::ISSUE_ORDER] = f_order;
    mask_c[sctc_pkg::ISSUE_OVERLAP] = prev_ok && !f_order &&
        cfg.check_enables[sctc_pkg::EN_OVERLAP] &&
        ((WW'(start_t) + WW'(cfg.overlap_tolerance_ms)) < WW'(last_end));
    mask_c[sctc_pkg::ISSUE_RANGE] = (cfg.media_length_ms != '0) &&
        (WW'(start_t) > (WW'(cfg.media_length_ms) + WW'(sctc_pkg::RANGE_SLACK_MS)));
  end

  // fast finding closes at the end of stage 2
  assign fast = s2_speed &&
                (PW'(s2_chars_prod) > s2_limit_prod);

  always_comb begin
    s2_mask_full = s2_mask;
    s2_mask_full[sctc_pkg::ISSUE_FAST] = fast;
  end

  // clean cues retire without queue space
  assign push       = s2_valid && (s2_mask_full != '0) && !queue_full;
  assign push_entry = '{mask: s2_mask_full, cue: s2_cue};

  assign adv2      = !s2_valid || (s2_mask_full == '0) || !queue_full;
  assign adv1      = !s1_valid || adv2;
  assign cue_stall = !adv1;
  assign accept    = cue_valid && adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev  <= 1'b0;
      last_start <= '0;
      last_end   <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
    end else begin
      if (accept) begin
        have_prev  <= 1'b1;
        last_start <= start_t;
        last_end   <= positive ? end_t : start_t;
      end
      if (adv1) begin
        s1_valid <= accept;
      end
      if (adv2) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mask  <= mask_c;
      s1_cue   <= cue_id;
      s1_speed <= cfg.check_enables[sctc_pkg::EN_SPEED] && positive && !is_empty &&
                  (dur > TW'(sctc_pkg::SPEED_MIN_DUR_MS));
      s1_dur   <= dur;
      s1_chars <= text_chars;
    end
    if (adv2 && s1_valid) begin
      s2_mask       <= s1_mask;
      s2_cue        <= s1_cue;
      s2_speed      <= s1_speed;
      s2_chars_prod <= sctc_pkg::CHARS_PROD_WIDTH'(s1_chars) *
                       sctc_pkg::CHARS_PROD_WIDTH'(sctc_pkg::CPS_SCALE);
      s2_limit_prod <= PW'(cfg.max_cps_tenths) * PW'(s1_dur);
    end
  end

endmodule

// ===== rtl/core/sctc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctc_queue - short FIFO of issue masks between front and back
// Register-based, first word visible at the head without a read cycle.
// ----------------------------------------------------------------------------
module sctc_queue #(
  parameter int QUEUE_DEPTH = sctc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  sctc_pkg::sctc_entry_t push_entry,
  input  logic                  pop,
  output sctc_pkg::sctc_entry_t head,
  output logic                  empty,
  output logic                  full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sctc_pkg::sctc_entry_t slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == CNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== rtl/core/sctc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctc_back - issue serializer
// Walks each queued mask from the lowest code up, one issue word per cycle
// unless stalled, into a registered output; marks each cue's final issue.
// ----------------------------------------------------------------------------
module sctc_back (
  input  logic                              clk,
  input  logic                              rst,
  input  sctc_pkg::sctc_entry_t             head,
  input  logic                              queue_empty,
  output logic                              pop,
  output logic                              issue_valid,
  input  logic                              issue_stall,
  output logic [sctc_pkg::CODE_WIDTH-1:0]   issue_code,
  output logic [sctc_pkg::SEV_WIDTH-1:0]    severity,
  output logic [sctc_pkg::CUE_WIDTH-1:0]    issue_cue,
  output logic                              last_issue
);

  logic [sctc_pkg::NUM_ISSUES-1:0] cur_mask;
  logic [sctc_pkg::CUE_WIDTH-1:0]  cur_cue;

  logic                              load;
  logic                              have_cur;
  logic                              src_ok;
  logic [sctc_pkg::NUM_ISSUES-1:0]   src_mask;
  logic [sctc_pkg::CUE_WIDTH-1:0]    src_cue;
  logic [sctc_pkg::NUM_ISSUES-1:0]   rest;
  logic [sctc_pkg::CODE_WIDTH-1:0]   pick;

  assign load     = !issue_valid || !issue_stall;
  assign have_cur = (cur_mask != '0);
  assign src_mask = have_cur ? cur_mask : head.mask;
  assign src_cue  = have_cur ? cur_cue : head.cue;
  assign src_ok   = have_cur || !queue_empty;
  assign pop      = load && !have_cur && !queue_empty;
  // clear the lowest set bit
  assign rest     = src_mask & (src_mask - 1'b1);

  // lowest set bit gives the next code
  always_comb begin
    pick = '0;
    for (int i = sctc_pkg::NUM_ISSUES - 1; i >= 0; i--) begin
      if (src_mask[i]) begin
        pick = sctc_pkg::CODE_WIDTH'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_valid <= 1'b0;
      cur_mask    <= '0;
    end else if (load) begin
      issue_valid <= src_ok;
      if (src_ok) begin
        cur_mask <= rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && src_ok) begin
      cur_cue    <= src_cue;
      issue_code <= pick;
      severity   <= sctc_pkg::issue_severity(pick);
      issue_cue  <= src_cue;
      last_issue <= (rest == '0);
    end
  end

endmodule

// ===== rtl/core/subtitle_cue_timing_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subtitle_cue_timing_checker - timing and reading-speed checks on cues
// Checks each cue for empty text, bad/short/long duration, start order,
// overlap with the previous cue, reading speed and media range, and emits
// one issue word per finding with the final one marked.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  -------------------------------
//  cue      in         cue_valid / cue_stall     group_start cue_id start_ms
//                                                end_ms is_empty text_chars
//  issue    out        issue_valid / issue_stall issue_code severity issue_cue
//                                                last_issue
//  config   in         APB psel/penable/pready   paddr pwrite pwdata prdata
//
//  Flow: one cue word is taken per cycle while cue_stall is low. It passes
//  through the compare stage and the cross-product stage and is pushed to
//  the queue, whose head the back registers into its output as the first
//  issue. The back emits one issue word per cycle while issue_stall is low;
//  clean cues cost the back nothing.
//  Stalls: the front stalls cue input only when the QUEUE_DEPTH-entry queue
//  is full and its last stage holds a cue with findings.
//  Reset: rst is synchronous; it restores register defaults, clears the
//  previous-cue tracking and empties the pipeline, queue and output.
// ----------------------------------------------------------------------------
module subtitle_cue_timing_checker #(
  parameter int TIME_WIDTH  = sctc_pkg::TIME_WIDTH_DEFAULT,
  parameter int QUEUE_DEPTH = sctc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sctc_pkg::CFG_ADDR_WIDTH-1:0]   paddr,
  input  logic [sctc_pkg::CFG_DATA_WIDTH-1:0]   pwdata,
  output logic [sctc_pkg::CFG_DATA_WIDTH-1:0]   prdata,
  output logic                                  pready,
  // cue channel
  input  logic                                  cue_valid,
  output logic                                  cue_stall,
  input  logic                                  group_start,
  input  logic [sctc_pkg::CUE_WIDTH-1:0]        cue_id,
  input  logic [sctc_pkg::FIELD_TIME_WIDTH-1:0] start_ms,
  input  logic [sctc_pkg::FIELD_TIME_WIDTH-1:0] end_ms,
  input  logic                                  is_empty,
  input  logic [sctc_pkg::CHARS_WIDTH-1:0]      text_chars,
  // issue channel
  output logic                                  issue_valid,
  input  logic                                  issue_stall,
  output logic [sctc_pkg::CODE_WIDTH-1:0]       issue_code,
  output logic [sctc_pkg::SEV_WIDTH-1:0]        severity,
  output logic [sctc_pkg::CUE_WIDTH-1:0]        issue_cue,
  output logic                                  last_issue
);

  sctc_pkg::sctc_cfg_t   cfg;
  sctc_pkg::sctc_entry_t push_entry;
  sctc_pkg::sctc_entry_t head;
  logic                  push;
  logic                  pop;
  logic                  queue_empty;
  logic                  queue_full;
  logic                  cfg_write;
  logic [sctc_pkg::REG_IDX_WIDTH-1:0] reg_idx;

  // ---------------------------------------------------------------------------
  // Register file: word registers at 4*index, no wait states
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_idx   = paddr[sctc_pkg::CFG_ADDR_WIDTH-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.check_enables        <= sctc_pkg::RST_CHECK_ENABLES;
      cfg.min_duration_ms      <= sctc_pkg::RST_MIN_DURATION;
      cfg.max_duration_ms      <= sctc_pkg::RST_MAX_DURATION;
      cfg.overlap_tolerance_ms <= sctc_pkg::RST_OVERLAP_TOL;
      cfg.max_cps_tenths       <= sctc_pkg::RST_MAX_CPS;
      cfg.media_length_ms      <= sctc_pkg::RST_MEDIA_LENGTH;
    end else if (cfg_write) begin
      unique case (reg_idx)
        sctc_pkg::REG_CHECK_ENABLES:
          cfg.check_enables <= pwdata[sctc_pkg::ENABLE_WIDTH-1:0];
        sctc_pkg::REG_MIN_DURATION:  cfg.min_duration_ms      <= pwdata;
        sctc_pkg::REG_MAX_DURATION:  cfg.max_duration_ms      <= pwdata;
        sctc_pkg::REG_OVERLAP_TOL:   cfg.overlap_tolerance_ms <= pwdata;
        sctc_pkg::REG_MAX_CPS:
          cfg.max_cps_tenths <= pwdata[sctc_pkg::CPS_WIDTH-1:0];
        sctc_pkg::REG_MEDIA_LENGTH:  cfg.media_length_ms      <= pwdata;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // Read back, zero-extended to the bus width
  always_comb begin
    unique case (reg_idx)
      sctc_pkg::REG_CHECK_ENABLES:
        prdata = sctc_pkg::CFG_DATA_WIDTH'(cfg.check_enables);
      sctc_pkg::REG_MIN_DURATION: prdata = cfg.min_duration_ms;
      sctc_pkg::REG_MAX_DURATION: prdata = cfg.max_duration_ms;
      sctc_pkg::REG_OVERLAP_TOL:  prdata = cfg.overlap_tolerance_ms;
      sctc_pkg::REG_MAX_CPS:
        prdata = sctc_pkg::CFG_DATA_WIDTH'(cfg.max_cps_tenths);
      sctc_pkg::REG_MEDIA_LENGTH: prdata = cfg.media_length_ms;
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Front: take cue words, track the previous cue, build the finding mask
  // ---------------------------------------------------------------------------
  sctc_front #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cue_valid   (cue_valid),
    .cue_stall   (cue_stall),
    .group_start (group_start),
    .cue_id      (cue_id),
    .start_ms    (start_ms),
    .end_ms      (end_ms),
    .is_empty    (is_empty),
    .text_chars  (text_chars),
    .push        (push),
    .push_entry  (push_entry),
    .queue_full  (queue_full)
  );

  // ---------------------------------------------------------------------------
  // Queue: hold masks so intake keeps running while issues drain
  // ---------------------------------------------------------------------------
  sctc_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (queue_empty),
    .full       (queue_full)
  );

  // ---------------------------------------------------------------------------
  // Back: expand each mask into issue words, lowest code first
  // ---------------------------------------------------------------------------
  sctc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .queue_empty (queue_empty),
    .pop         (pop),
    .issue_valid (issue_valid),
    .issue_stall (issue_stall),
    .issue_code  (issue_code),
    .severity    (severity),
    .issue_cue   (issue_cue),
    .last_issue  (last_issue)
  );

endmodule
